// ===== rtl/core/hpfpu_pkg.sv =====
package hpfpu_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_SQRT = 3'd4,
    OP_CMP  = 3'd5,
    OP_F2I  = 3'd6,
    OP_I2F  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    K_ZERO = 3'd0,
    K_FIN  = 3'd1,
    K_INF  = 3'd2,
    K_QNAN = 3'd3,
    K_SNAN = 3'd4
  } kind_t;

  localparam logic [15:0] QNAN_BITS = 16'h7E00;
  localparam logic [15:0] INF_BITS  = 16'h7C00;

  // Fixed-point value with exponent of its least significant bit.
  typedef struct packed {
    logic        sign;
    kind_t       kind;
    logic [10:0] sig;
    logic signed [6:0] exp;
  } hval_t;

  // One classified item as it travels from the front part to the back part.
  typedef struct packed {
    op_t         op;
    logic [15:0] a;
    logic [15:0] b;
    hval_t       va;
    hval_t       vb;
  } item_t;

  typedef struct packed {
    logic [15:0] result;
    logic        flag_over;
    logic        flag_less;
    logic        flag_less_equal;
    logic        flag_greater;
    logic        flag_greater_equal;
    logic        flag_equal;
    logic        flag_not_equal;
    logic        flag_zero;
  } res_t;

  function automatic hval_t unpack(input logic [15:0] bits);
    hval_t v;
    logic [4:0] be;
    logic [9:0] fr;
    be = bits[14:10];
    fr = bits[9:0];
    v.sign = bits[15];
    v.sig = '0;
    v.exp = -7'sd24;
    if (be == 5'd31) begin
      v.kind = (fr == '0) ? K_INF : (fr[9] ? K_QNAN : K_SNAN);
    end else if (be == '0 && fr == '0) begin
      v.kind = K_ZERO;
    end else begin
      v.kind = K_FIN;
      v.sig = (be != '0) ? {1'b1, fr} : {1'b0, fr};
      v.exp = $signed({2'b00, ((be != '0) ? be : 5'd1)}) - 7'sd25;
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/half_precision_fpu_core.sv =====
// Pipelined binary16 unit: one beat of {operation, operand_a, operand_b} in gives one
// beat of {result, flags} out, in order. A four-entry queue holds classified items
// ahead of the execution pipeline, where divide and square root run as fourteen
// restoring steps, two per stage over seven stages, and every operation takes the same
// path. A beat is taken every cycle while the output drains, and an input beat passes
// a queue entry, stage registers st[0] to st[7] and the result register on its way
// out. A stalled output holds the whole pipeline; the queue then takes up to four more
// beats before s_tready falls. Any exception yields result +0 with flag_over set.
module half_precision_fpu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // operation[2:0], operand_a[18:3], operand_b[34:19]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // result[15:0]
  output logic [7:0]  m_tuser    // flag_over, less, less_equal, greater,
                                 // greater_equal, equal, not_equal, zero
);
  import hpfpu_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  hpfpu_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  hpfpu_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule

// ===== rtl/core/hpfpu_front.sv =====
module hpfpu_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,
  output logic                 q_valid,
  input  logic                 q_ready,
  output hpfpu_pkg::item_t     q_item
);
  import hpfpu_pkg::*;

  localparam int Depth = 4;
  localparam int Aw = $clog2(Depth);

  item_t       mem [Depth];
  logic [Aw-1:0] wr_ptr;
  logic [Aw-1:0] rd_ptr;
  logic [Aw:0]   count;
  item_t       in_item;
  logic        push;
  logic        pop;

  always_comb begin
    in_item.op = op_t'(s_tdata[2:0]);
    in_item.a  = s_tdata[18:3];
    in_item.b  = s_tdata[34:19];
    in_item.va = unpack(s_tdata[18:3]);
    in_item.vb = unpack(s_tdata[34:19]);
  end

  assign s_tready = (count != Aw'(0) + (Aw+1)'(Depth));
  assign push = s_tvalid && s_tready;
  assign q_valid = (count != '0);
  assign pop = q_valid && q_ready;
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (Aw+1)'(Depth)) else $error("queue count out of range");
  a_empty_no_valid: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !q_valid) else $error("valid from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1)) else $error("count slip");

endmodule

// ===== rtl/core/hpfpu_back.sv =====
module hpfpu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  hpfpu_pkg::item_t  q_item,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,
  output logic [7:0]        m_tuser
);
  import hpfpu_pkg::*;

  // Seven stages of two restoring steps each give the fourteen quotient or root bits.
  localparam int Iter = 7;

  // Operation to an exact (sign, magnitude, exponent, sticky) form. Divide and square
  // root carry their partial remainder and quotient or root through the step stages.
  typedef struct packed {
    logic        valid_fin;
    logic        sign;
    logic [63:0] mag;
    logic signed [8:0] exp;
    logic        sticky;
    logic        special;
    logic [15:0] special_res;
    logic        exc;
    logic        no_exc;
    logic [7:0]  cmp;
    logic        it_div;
    logic        it_sqrt;
    logic [10:0] dsr;
    logic [27:0] rad;
    logic [17:0] rem;
    logic [13:0] quo;
  } mid_t;

  mid_t         st [Iter+1];
  logic [Iter:0] sv;
  logic         res_valid;
  res_t         res;
  logic         advance;
  mid_t         m_next;
  res_t         r_next;

  function automatic logic [3:0] lzc11(input logic [10:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i <= 10; i++) if (v[i]) n = 4'(10 - i);
    return n;
  endfunction

  function automatic mid_t it_step(input mid_t m);
    mid_t s;
    logic [17:0] t;
    s = m;
    if (m.it_div) begin
      if (s.rem >= {7'd0, s.dsr}) begin
        s.rem = s.rem - {7'd0, s.dsr};
        s.quo = {s.quo[12:0], 1'b1};
      end else begin
        s.quo = {s.quo[12:0], 1'b0};
      end
      s.rem = {s.rem[16:0], 1'b0};
    end else if (m.it_sqrt) begin
      s.rem = {s.rem[15:0], s.rad[27:26]};
      s.rad = {s.rad[25:0], 2'b00};
      t = {2'b00, s.quo, 2'b01};
      if (s.rem >= t) begin
        s.rem = s.rem - t;
        s.quo = {s.quo[12:0], 1'b1};
      end else begin
        s.quo = {s.quo[12:0], 1'b0};
      end
    end
    return s;
  endfunction

  function automatic mid_t do_op(input item_t it);
    mid_t m;
    hval_t a;
    hval_t b;
    logic signed [8:0] emin;
    logic [63:0] x;
    logic [63:0] y;
    logic signed [8:0] la;
    logic signed [8:0] lb;
    logic [11:0] sx;
    logic signed [8:0] se;
    logic signed [16:0] ka;
    logic signed [16:0] kb;
    logic anan;
    logic bnan;
    logic [15:0] iv;
    logic [16:0] mg;
    logic [15:0] op_b;
    a = it.va;
    op_b = it.b;
    if (it.op == OP_SUB) op_b = it.b ^ 16'h8000;
    b = unpack(op_b);
    m = '0;
    m.exp = 9'sd0;
    case (it.op)
      OP_ADD, OP_SUB: begin
        if (a.kind == K_SNAN || b.kind == K_SNAN) begin
          m.exc = 1'b1;
        end else if (a.kind == K_QNAN || b.kind == K_QNAN) begin
          m.special = 1'b1; m.special_res = QNAN_BITS;
        end else if (a.kind == K_INF && b.kind == K_INF) begin
          if (a.sign != b.sign) m.exc = 1'b1;
          else begin m.special = 1'b1; m.special_res = {a.sign, 15'h7C00}; end
        end else if (a.kind == K_INF) begin
          m.special = 1'b1; m.special_res = {a.sign, 15'h7C00};
        end else if (b.kind == K_INF) begin
          m.special = 1'b1; m.special_res = {b.sign, 15'h7C00};
        end else begin
          emin = (a.exp < b.exp) ? 9'(a.exp) : 9'(b.exp);
          x = 64'(a.sig) << (9'(a.exp) - emin);
          y = 64'(b.sig) << (9'(b.exp) - emin);
          m.exp = emin;
          m.valid_fin = 1'b1;
          if (a.sign == b.sign) begin
            if (a.kind == K_ZERO && b.kind == K_ZERO) begin
              m.valid_fin = 1'b0; m.special = 1'b1; m.special_res = {a.sign, 15'h0};
            end else begin
              m.sign = a.sign; m.mag = x + y;
            end
          end else if (x > y) begin
            m.sign = a.sign; m.mag = x - y;
          end else if (y > x) begin
            m.sign = b.sign; m.mag = y - x;
          end else begin
            m.valid_fin = 1'b0; m.special = 1'b1; m.special_res = 16'h0;
          end
        end
      end
      OP_MUL: begin
        if (a.kind == K_SNAN || b.kind == K_SNAN) m.exc = 1'b1;
        else if (a.kind == K_QNAN || b.kind == K_QNAN) begin
          m.special = 1'b1; m.special_res = QNAN_BITS;
        end else if (a.kind == K_INF || b.kind == K_INF) begin
          if (a.kind == K_ZERO || b.kind == K_ZERO) m.exc = 1'b1;
          else begin m.special = 1'b1; m.special_res = {a.sign ^ b.sign, 15'h7C00}; end
        end else begin
          m.valid_fin = 1'b1;
          m.sign = a.sign ^ b.sign;
          m.mag = 64'({11'd0, a.sig} * {11'd0, b.sig});
          m.exp = 9'(a.exp) + 9'(b.exp);
        end
      end
      OP_DIV: begin
        if (a.kind == K_SNAN || b.kind == K_SNAN) m.exc = 1'b1;
        else if (a.kind == K_QNAN || b.kind == K_QNAN) begin
          m.special = 1'b1; m.special_res = QNAN_BITS;
        end else if (a.kind == K_INF) begin
          if (b.kind == K_INF) m.exc = 1'b1;
          else begin m.special = 1'b1; m.special_res = {a.sign ^ b.sign, 15'h7C00}; end
        end else if (b.kind == K_INF) begin
          m.special = 1'b1; m.special_res = {a.sign ^ b.sign, 15'h0};
        end else if (b.kind == K_ZERO) m.exc = 1'b1;
        else if (a.kind == K_ZERO) begin
          m.special = 1'b1; m.special_res = {a.sign ^ b.sign, 15'h0};
        end else begin
          // Both significands are normalized, so the quotient has fourteen bits.
          la = $signed({5'd0, lzc11(a.sig)});
          lb = $signed({5'd0, lzc11(b.sig)});
          m.valid_fin = 1'b1;
          m.sign = a.sign ^ b.sign;
          m.it_div = 1'b1;
          m.dsr = b.sig << lb;
          m.rem = {7'd0, 11'(a.sig << la)};
          m.exp = 9'(a.exp) - la - 9'(b.exp) + lb - 9'sd13;
        end
      end
      OP_SQRT: begin
        if (a.kind == K_SNAN) m.exc = 1'b1;
        else if (a.kind == K_QNAN) begin
          m.special = 1'b1; m.special_res = QNAN_BITS;
        end else if (a.kind == K_ZERO) begin
          m.special = 1'b1; m.special_res = it.a;
        end else if (a.sign) m.exc = 1'b1;
        else if (a.kind == K_INF) begin
          m.special = 1'b1; m.special_res = INF_BITS;
        end else begin
          la = $signed({5'd0, lzc11(a.sig)});
          se = 9'(a.exp) - la;
          sx = {1'b0, 11'(a.sig << la)};
          if (se[0]) begin sx = {sx[10:0], 1'b0}; se = se - 9'sd1; end
          se = se - 9'sd16;
          m.valid_fin = 1'b1;
          m.it_sqrt = 1'b1;
          m.rad = {sx, 16'd0};
          m.exp = se >>> 1;
        end
      end
      OP_CMP: begin
        m.special = 1'b1;
        m.special_res = '0;
        m.no_exc = 1'b1;
        anan = (a.kind == K_QNAN || a.kind == K_SNAN);
        bnan = (it.vb.kind == K_QNAN || it.vb.kind == K_SNAN);
        m.cmp[0] = (a.kind == K_ZERO);
        if (anan || bnan) begin
          m.cmp[1] = 1'b1;
        end else begin
          ka = {2'b00, it.a[14:0]};
          kb = {2'b00, it.b[14:0]};
          if (it.a[15]) ka = -ka;
          if (it.b[15]) kb = -kb;
          m.cmp[7] = ka < kb;
          m.cmp[6] = ka <= kb;
          m.cmp[5] = ka > kb;
          m.cmp[4] = ka >= kb;
          m.cmp[3] = ka == kb;
          m.cmp[1] = ka != kb;
        end
      end
      OP_F2I: begin
        m.special = 1'b1;
        m.no_exc = 1'b1;
        if (a.kind == K_QNAN || a.kind == K_SNAN) m.special_res = '0;
        else if (a.kind == K_INF) m.special_res = a.sign ? 16'h8000 : 16'h7FFF;
        else begin
          if (a.exp >= 0) begin
            mg = (a.exp > 7'sd6) ? 17'h1FFFF : 17'(32'(a.sig) << a.exp);
          end else begin
            mg = 17'(a.sig >> (-a.exp));
          end
          if (a.sign) begin
            if (mg > 17'd32768) mg = 17'd32768;
            m.special_res = 16'(17'd0 - mg);
          end else begin
            if (mg > 17'd32767) mg = 17'd32767;
            m.special_res = mg[15:0];
          end
        end
      end
      default: begin
        m.no_exc = 1'b1;
        iv = it.a;
        m.valid_fin = (iv != '0);
        if (iv == '0) begin m.special = 1'b1; m.special_res = '0; end
        m.sign = iv[15];
        m.mag = iv[15] ? 64'(17'h10000 - {1'b0, iv}) : 64'(iv);
        m.exp = 9'sd0;
      end
    endcase
    return m;
  endfunction

  function automatic res_t do_round(input mid_t m);
    res_t r;
    int len;
    logic signed [9:0] qe;
    logic signed [9:0] sh;
    logic [63:0] kept;
    logic rnd;
    logic stk;
    logic tiny;
    logic exc;
    logic signed [9:0] be;
    if (m.it_div || m.it_sqrt) begin
      m.mag = 64'(m.quo);
      m.sticky = (m.rem != '0);
    end
    r = '0;
    exc = m.exc;
    r.result = m.special_res;
    if (m.valid_fin) begin
      len = 0;
      for (int i = 0; i < 64; i++) if (m.mag[i]) len = i + 1;
      qe = 10'(m.exp) + 10'(len) - 10'sd11;
      tiny = qe < -10'sd24;
      if (tiny) qe = -10'sd24;
      sh = qe - 10'(m.exp);
      stk = m.sticky;
      rnd = 1'b0;
      if (sh > 10'sd63) begin
        kept = '0; stk = 1'b1;
      end else if (sh > 0) begin
        kept = m.mag >> sh;
        rnd = m.mag[sh - 1];
        if ((m.mag & ((64'd1 << (sh - 1)) - 64'd1)) != '0) stk = 1'b1;
      end else begin
        kept = m.mag << (-sh);
      end
      if (rnd && (stk || kept[0])) kept = kept + 64'd1;
      if (kept >= 64'd2048) begin kept = kept >> 1; qe = qe + 10'sd1; end
      if (tiny && (rnd || stk)) exc = 1'b1;
      if (kept >= 64'd1024) begin
        be = qe + 10'sd25;
        if (be >= 10'sd31) exc = 1'b1;
        else r.result = {m.sign, be[4:0], kept[9:0]};
      end else begin
        r.result = {m.sign, 5'd0, kept[9:0]};
      end
    end
    if (m.no_exc) exc = 1'b0;
    if (exc) r.result = '0;
    r.flag_over = exc;
    r.flag_less = m.cmp[7];
    r.flag_less_equal = m.cmp[6];
    r.flag_greater = m.cmp[5];
    r.flag_greater_equal = m.cmp[4];
    r.flag_equal = m.cmp[3];
    r.flag_not_equal = m.cmp[1];
    r.flag_zero = m.cmp[0];
    return r;
  endfunction

  assign m_next = do_op(q_item);
  assign r_next = do_round(st[Iter]);

  assign advance = !res_valid || m_tready;
  assign q_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv        <= '0;
      res_valid <= 1'b0;
    end else if (advance) begin
      sv        <= {sv[Iter-1:0], q_valid};
      res_valid <= sv[Iter];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0] <= m_next;
      for (int k = 1; k <= Iter; k++) st[k] <= it_step(it_step(st[k-1]));
      res <= r_next;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = res.result;
  assign m_tuser  = {res.flag_zero, res.flag_not_equal, res.flag_equal,
                     res.flag_greater_equal, res.flag_greater, res.flag_less_equal,
                     res.flag_less, res.flag_over};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("output changed while stalled");
  a_over_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0)) else $error("flag without zero");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (sv[0] && !advance) |=> sv[0]) else $error("stage one dropped");

endmodule

// ===== tb/tb_half_precision_fpu_core.sv =====
module tb_half_precision_fpu_core;
  timeunit 1ns;
  timeprecision 1ps;
  import hpfpu_pkg::*;

  typedef struct {
    logic [15:0] result;
    logic [7:0]  flags;
  } fpu_out_t;

  typedef struct {
    logic        sign;
    kind_t       kind;
    logic [63:0] sig;
    int          exp;
  } half_num_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [7:0]  m_tuser;

  fpu_out_t expected_q[$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       mismatches = 0;
  int       cycles = 0;

  half_precision_fpu_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic half_num_t classify(logic [15:0] bits);
    half_num_t v;
    v.sign = bits[15];
    v.sig = 0;
    v.exp = -24;
    if (bits[14:10] == 5'd31) begin
      v.kind = (bits[9:0] == 0) ? K_INF : (bits[9] ? K_QNAN : K_SNAN);
    end else if (bits[14:0] == 0) begin
      v.kind = K_ZERO;
    end else begin
      v.kind = K_FIN;
      v.sig = (bits[14:10] != 0) ? {53'd0, 1'b1, bits[9:0]} : {54'd0, bits[9:0]};
      v.exp = ((bits[14:10] != 0) ? int'(bits[14:10]) : 1) - 25;
    end
    return v;
  endfunction

  function automatic logic [15:0] round_half(logic sign, logic [63:0] mag, int exp,
                                             logic sticky, ref logic exc);
    int          len;
    int          q;
    int          sh;
    logic [63:0] kept;
    logic        rnd;
    logic        tiny;
    len = 0;
    rnd = 1'b0;
    if (mag == 0) return {sign, 15'd0};
    for (int i = 0; i < 64; i++) if (mag[i]) len = i + 1;
    q = exp + len - 11;
    tiny = q < -24;
    if (tiny) q = -24;
    sh = q - exp;
    if (sh > 63) begin
      kept = 0;
      sticky = 1'b1;
    end else if (sh > 0) begin
      kept = mag >> sh;
      rnd = mag[sh-1];
      if ((mag & ((64'd1 << (sh - 1)) - 1)) != 0) sticky = 1'b1;
    end else begin
      kept = mag << (-sh);
    end
    if (rnd && (sticky || kept[0])) kept++;
    if (kept >= 2048) begin
      kept >>= 1;
      q++;
    end
    if (tiny && (rnd || sticky)) exc = 1'b1;
    if (kept >= 1024) begin
      if (q + 25 >= 31) begin
        exc = 1'b1;
        return 16'd0;
      end
      return {sign, 5'(q + 25), kept[9:0]};
    end
    return {sign, 5'd0, kept[9:0]};
  endfunction

  function automatic logic [15:0] half_add(logic [15:0] ab, logic [15:0] bb, ref logic exc);
    half_num_t   a;
    half_num_t   b;
    int          emin;
    logic [63:0] x;
    logic [63:0] y;
    a = classify(ab);
    b = classify(bb);
    if (a.kind == K_SNAN || b.kind == K_SNAN) begin exc = 1'b1; return 0; end
    if (a.kind == K_QNAN || b.kind == K_QNAN) return QNAN_BITS;
    if (a.kind == K_INF && b.kind == K_INF) begin
      if (a.sign != b.sign) begin exc = 1'b1; return 0; end
      return {a.sign, 15'd0} | INF_BITS;
    end
    if (a.kind == K_INF) return {a.sign, 15'd0} | INF_BITS;
    if (b.kind == K_INF) return {b.sign, 15'd0} | INF_BITS;
    emin = (a.exp < b.exp) ? a.exp : b.exp;
    x = a.sig << (a.exp - emin);
    y = b.sig << (b.exp - emin);
    if (a.sign == b.sign) return round_half(a.sign, x + y, emin, 1'b0, exc);
    if (x > y) return round_half(a.sign, x - y, emin, 1'b0, exc);
    if (y > x) return round_half(b.sign, y - x, emin, 1'b0, exc);
    return 0;
  endfunction

  function automatic logic [15:0] half_mul(logic [15:0] ab, logic [15:0] bb, ref logic exc);
    half_num_t a;
    half_num_t b;
    logic      s;
    a = classify(ab);
    b = classify(bb);
    s = a.sign ^ b.sign;
    if (a.kind == K_SNAN || b.kind == K_SNAN) begin exc = 1'b1; return 0; end
    if (a.kind == K_QNAN || b.kind == K_QNAN) return QNAN_BITS;
    if (a.kind == K_INF || b.kind == K_INF) begin
      if (a.kind == K_ZERO || b.kind == K_ZERO) begin exc = 1'b1; return 0; end
      return {s, 15'd0} | INF_BITS;
    end
    return round_half(s, a.sig * b.sig, a.exp + b.exp, 1'b0, exc);
  endfunction

  function automatic logic [15:0] half_div(logic [15:0] ab, logic [15:0] bb, ref logic exc);
    half_num_t   a;
    half_num_t   b;
    logic        s;
    logic [63:0] num;
    a = classify(ab);
    b = classify(bb);
    s = a.sign ^ b.sign;
    if (a.kind == K_SNAN || b.kind == K_SNAN) begin exc = 1'b1; return 0; end
    if (a.kind == K_QNAN || b.kind == K_QNAN) return QNAN_BITS;
    if (a.kind == K_INF) begin
      if (b.kind == K_INF) begin exc = 1'b1; return 0; end
      return {s, 15'd0} | INF_BITS;
    end
    if (b.kind == K_INF) return {s, 15'd0};
    if (b.kind == K_ZERO) begin exc = 1'b1; return 0; end
    if (a.kind == K_ZERO) return {s, 15'd0};
    num = a.sig << 40;
    return round_half(s, num / b.sig, a.exp - 40 - b.exp, (num % b.sig) != 0, exc);
  endfunction

  function automatic logic [15:0] half_sqrt(logic [15:0] ab, ref logic exc);
    half_num_t   a;
    logic [63:0] x;
    logic [63:0] root;
    logic [63:0] bit_w;
    int          e;
    a = classify(ab);
    root = 0;
    bit_w = 64'd1 << 62;
    if (a.kind == K_SNAN) begin exc = 1'b1; return 0; end
    if (a.kind == K_QNAN) return QNAN_BITS;
    if (a.kind == K_ZERO) return ab;
    if (a.sign) begin exc = 1'b1; return 0; end
    if (a.kind == K_INF) return INF_BITS;
    x = a.sig;
    e = a.exp;
    if (e % 2 != 0) begin
      x <<= 1;
      e -= 1;
    end
    x <<= 40;
    e -= 40;
    while (bit_w > x) bit_w >>= 2;
    while (bit_w != 0) begin
      if (x >= root + bit_w) begin
        x -= root + bit_w;
        root = (root >> 1) + bit_w;
      end else begin
        root >>= 1;
      end
      bit_w >>= 2;
    end
    return round_half(1'b0, root, e / 2, x != 0, exc);
  endfunction

  function automatic logic [15:0] half_to_int(logic [15:0] ab);
    half_num_t   a;
    logic [63:0] mag;
    a = classify(ab);
    if (a.kind == K_QNAN || a.kind == K_SNAN) return 0;
    if (a.kind == K_INF) return a.sign ? 16'h8000 : 16'h7FFF;
    mag = (a.exp >= 0) ? (a.sig << a.exp) : (a.sig >> (-a.exp));
    if (a.sign) begin
      if (mag > 32768) mag = 32768;
      return 16'(-mag);
    end
    if (mag > 32767) mag = 32767;
    return mag[15:0];
  endfunction

  function automatic fpu_out_t fpu_predict(op_t op, logic [15:0] ab, logic [15:0] bb);
    fpu_out_t  r;
    logic      exc;
    half_num_t a;
    half_num_t b;
    int        ka;
    int        kb;
    logic      dummy;
    r.result = 0;
    r.flags = 0;
    exc = 1'b0;
    dummy = 1'b0;
    case (op)
      OP_ADD:  r.result = half_add(ab, bb, exc);
      OP_SUB:  r.result = half_add(ab, bb ^ 16'h8000, exc);
      OP_MUL:  r.result = half_mul(ab, bb, exc);
      OP_DIV:  r.result = half_div(ab, bb, exc);
      OP_SQRT: r.result = half_sqrt(ab, exc);
      OP_CMP: begin
        a = classify(ab);
        b = classify(bb);
        r.flags[7] = a.kind == K_ZERO;
        if (a.kind inside {K_QNAN, K_SNAN} || b.kind inside {K_QNAN, K_SNAN}) begin
          r.flags[6] = 1'b1;
        end else begin
          ka = ab[15] ? -int'(ab[14:0]) : int'(ab[14:0]);
          kb = bb[15] ? -int'(bb[14:0]) : int'(bb[14:0]);
          r.flags[1] = ka < kb;
          r.flags[2] = ka <= kb;
          r.flags[3] = ka > kb;
          r.flags[4] = ka >= kb;
          r.flags[5] = ka == kb;
          r.flags[6] = ka != kb;
        end
      end
      OP_F2I: r.result = half_to_int(ab);
      default: begin
        if (ab[15]) r.result = round_half(1'b1, 64'(17'h10000 - ab), 0, 1'b0, dummy);
        else r.result = round_half(1'b0, 64'(ab), 0, 1'b0, dummy);
      end
    endcase
    if (exc) r.result = 0;
    r.flags[0] = exc;
    return r;
  endfunction

  task automatic send_op(op_t op, logic [15:0] a, logic [15:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, b, a, op};
    expected_q.push_back(fpu_predict(op, a, b));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_half();
    case ($urandom_range(9))
      0: return {1'($urandom), 5'd31, 10'($urandom)};
      1: return {1'($urandom), 5'd0, 10'($urandom)};
      2: return {1'($urandom), 5'($urandom_range(1, 3)), 10'($urandom)};
      3: return {1'($urandom), 5'($urandom_range(27, 30)), 10'($urandom)};
      4: return {1'($urandom), 15'd0};
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      m_tready <= !($urandom_range(99) < recv_idle_pct);
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat %h/%h", m_tdata, m_tuser);
        end else begin
          if (m_tdata !== expected_q[0].result || m_tuser !== expected_q[0].flags) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %h/%b, got %h/%b", expected_q[0].result,
                       expected_q[0].flags, m_tdata, m_tuser);
          end
          void'(expected_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 200000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_directed();
    logic [15:0] specials[12] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
                                  16'h7C01, 16'h7BFF, 16'hFBFF, 16'h0001, 16'h8001,
                                  16'h0400, 16'h3C00};
    for (int k = 0; k < 8; k++) begin
      send_op(op_t'(k), specials[k], specials[(k * 5 + 3) % 12]);
      send_op(op_t'(k), specials[k + 4], specials[k + 2]);
    end
    send_op(OP_SUB, 16'h7C00, 16'h7C00);
    send_op(OP_MUL, 16'h0000, 16'hFC00);
    send_op(OP_DIV, 16'h0000, 16'h8000);
    send_op(OP_DIV, 16'h3C00, 16'h0000);
    send_op(OP_SQRT, 16'hBC00, 16'h0000);
    send_op(OP_ADD, 16'h8000, 16'h8000);
    send_op(OP_MUL, 16'h7BFF, 16'h7BFF);
    send_op(OP_MUL, 16'h0001, 16'h3800);
    send_op(OP_I2F, 16'h8000, 16'hFFFF);
  endtask

  task automatic test_random(int count);
    op_t op;
    for (int n = 0; n < count; n++) begin
      op = op_t'($urandom_range(7));
      send_op(op, (op == OP_I2F) ? 16'($urandom) : rand_half(), rand_half());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 17;
    recv_idle_pct = 46;
    test_random(310);
    send_idle_pct = 46;
    recv_idle_pct = 17;
    test_random(310);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(310);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
